@@ src/tmf_pkg.sv @@
// Package for the trimmed-mean sample filter: item structs, widths and
// the command/status structs between controller and datapath.
// No dependencies.
package tmf_pkg;

  // Field widths
  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 8;
  localparam int CHAN_W        = 2;
  localparam int WC_W          = 8;
  localparam int SUM_W         = 20;
  localparam int AVG_W         = 20;
  localparam int CNT_W         = 8;

  // Window count limits
  localparam logic [WC_W-1:0] WC_RESET = WC_W'(8);
  localparam logic [WC_W-1:0] WC_LIMIT = WC_W'(253);
  localparam int              EXTRA_SAMPLES = 2;

  // Divider: radix-16 restoring, four quotient bits per cycle
  localparam int DIV_DIGITS   = 4;
  localparam int DIVIDEND_W   = SUM_W + FRACTION_BITS;
  localparam int DIV_ITER     = (DIVIDEND_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int DIV_PAD_W    = DIV_ITER * DIV_DIGITS;
  localparam int DIV_CNT_W    = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CHAN_W-1:0]      channel;
  } sample_item_t;

  typedef struct packed {
    logic [AVG_W-1:0]  average;
    logic [CHAN_W-1:0] result_channel;
  } result_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic accum;      // take sample into window
    logic load_pass;  // load pass-through result, clear window
    logic trim;       // form dividend, clear window
    logic div_step;   // one divider iteration
  } tmf_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pass;       // window count selects pass-through
    logic last;       // next sample closes the window
    logic div_end;    // divider on its final iteration
  } tmf_sts_t;

endpackage

@@ src/tmf_ctrl.sv @@
// Controller for the trimmed-mean sample filter: handshakes and sequencing.
// Depends on tmf_pkg.
module tmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              smp_valid,
  output logic              smp_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  tmf_pkg::tmf_sts_t sts,
  output tmf_pkg::tmf_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TRIM = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       res_valid_next;
  logic       take;
  logic       makes_result;

  // An item that yields a result needs the output register free
  assign makes_result = sts.pass || sts.last;
  assign smp_ready    = (state == ST_IDLE) && (!res_valid || !makes_result);
  assign take         = smp_valid && smp_ready;

  // Commands and next state
  always_comb begin
    cmd            = '0;
    state_next     = state;
    res_valid_next = res_valid && !res_ready;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (sts.pass) begin
            cmd.load_pass  = 1'b1;
            res_valid_next = 1'b1;
          end else begin
            cmd.accum = 1'b1;
            if (sts.last) state_next = ST_TRIM;
          end
        end
      end
      ST_TRIM: begin
        cmd.trim   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_end) begin
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

@@ src/tmf_dpath.sv @@
// Datapath for the trimmed-mean sample filter: window count register,
// window accumulators, iterative divider and the result register.
// Depends on tmf_pkg.
module tmf_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [tmf_pkg::WC_W-1:0]    cfg_window_count,
  input  tmf_pkg::sample_item_t       smp_item,
  input  tmf_pkg::tmf_cmd_t           cmd,
  output tmf_pkg::tmf_sts_t           sts,
  output tmf_pkg::result_item_t       res_item
);

  localparam int PASS_W = tmf_pkg::SAMPLE_BITS + tmf_pkg::FRACTION_BITS;
  localparam int TRIM_W = tmf_pkg::SUM_W + 1;

  logic [tmf_pkg::WC_W-1:0]        window_count;
  logic [tmf_pkg::WC_W-1:0]        n_eff;
  logic [tmf_pkg::CNT_W-1:0]       samples_seen;
  logic [tmf_pkg::SUM_W-1:0]       running_sum;
  logic [tmf_pkg::SAMPLE_BITS-1:0] running_max;
  logic [tmf_pkg::SAMPLE_BITS-1:0] running_min;
  logic [tmf_pkg::CHAN_W-1:0]      last_chan;

  logic [tmf_pkg::WC_W-1:0]        divisor;
  logic [tmf_pkg::WC_W-1:0]        rem;
  logic [tmf_pkg::WC_W-1:0]        rem_next;
  logic [tmf_pkg::DIV_PAD_W-1:0]   quot;
  logic [tmf_pkg::DIV_PAD_W-1:0]   quot_next;
  logic [tmf_pkg::DIV_CNT_W-1:0]   div_cnt;

  logic [TRIM_W-1:0]               extremes;
  logic [TRIM_W-1:0]               trimmed;
  logic [PASS_W-1:0]               pass_val;
  logic [tmf_pkg::AVG_W-1:0]       pass_avg;
  logic [tmf_pkg::AVG_W-1:0]       div_avg;
  logic [tmf_pkg::SAMPLE_BITS-1:0] s;

  assign s = smp_item.sample;

  // Window count register; values above the limit act as the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= tmf_pkg::WC_RESET;
    end else if (cfg_valid) begin
      window_count <= cfg_window_count;
    end
  end

  assign n_eff    = (window_count > tmf_pkg::WC_LIMIT) ? tmf_pkg::WC_LIMIT : window_count;
  assign sts.pass = (n_eff <= tmf_pkg::WC_W'(1));
  assign sts.last = ({1'b0, samples_seen} + 9'd1)
                    >= ({1'b0, n_eff} + 9'(tmf_pkg::EXTRA_SAMPLES));
  assign sts.div_end = (div_cnt == tmf_pkg::DIV_CNT_W'(tmf_pkg::DIV_ITER - 1));

  // Window accumulators; the first sample loads both extremes
  always_ff @(posedge clk) begin
    if (rst || cmd.load_pass || cmd.trim) begin
      samples_seen <= '0;
      running_sum  <= '0;
      running_max  <= '0;
      running_min  <= '0;
    end else if (cmd.accum) begin
      samples_seen <= samples_seen + tmf_pkg::CNT_W'(1);
      running_sum  <= running_sum + tmf_pkg::SUM_W'(s);
      if (samples_seen == '0) begin
        running_max <= s;
        running_min <= s;
      end else begin
        if (s > running_max) running_max <= s;
        if (s < running_min) running_min <= s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) last_chan <= smp_item.channel;
  end

  // Sum less both extremes, floored at zero
  assign extremes = TRIM_W'(running_max) + TRIM_W'(running_min);
  assign trimmed  = ({1'b0, running_sum} >= extremes) ? ({1'b0, running_sum} - extremes) : '0;

  // Divider iteration: DIV_DIGITS restoring steps, MSB first
  always_comb begin
    logic [tmf_pkg::WC_W:0]        t;
    logic [tmf_pkg::WC_W-1:0]      r;
    logic [tmf_pkg::DIV_PAD_W-1:0] q;
    r = rem;
    q = quot;
    t = '0;
    for (int i = 0; i < tmf_pkg::DIV_DIGITS; i++) begin
      t = {r, q[tmf_pkg::DIV_PAD_W-1]};
      q = {q[tmf_pkg::DIV_PAD_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
      r = t[tmf_pkg::WC_W-1:0];
    end
    rem_next  = r;
    quot_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.trim) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + tmf_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      divisor <= n_eff;
      rem     <= '0;
      quot    <= tmf_pkg::DIV_PAD_W'(
                   tmf_pkg::DIVIDEND_W'(trimmed[tmf_pkg::SUM_W-1:0]) << tmf_pkg::FRACTION_BITS);
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  // Saturate to the result width
  assign pass_val = PASS_W'(s) << tmf_pkg::FRACTION_BITS;
  assign pass_avg = ({tmf_pkg::AVG_W'(0), pass_val} > {PASS_W'(0), tmf_pkg::AVG_MAX})
                    ? tmf_pkg::AVG_MAX : tmf_pkg::AVG_W'(pass_val);
  assign div_avg  = ({tmf_pkg::AVG_W'(0), quot_next}
                     > {tmf_pkg::DIV_PAD_W'(0), tmf_pkg::AVG_MAX})
                    ? tmf_pkg::AVG_MAX : tmf_pkg::AVG_W'(quot_next);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_pass) begin
      res_item.average        <= pass_avg;
      res_item.result_channel <= smp_item.channel;
    end else if (cmd.div_step && sts.div_end) begin
      res_item.average        <= div_avg;
      res_item.result_channel <= last_chan;
    end
  end

endmodule

@@ src/trimmed_mean_sample_filter_unit.sv @@
// Top level of the trimmed-mean sample filter: controller plus datapath.
// Depends on tmf_pkg, tmf_ctrl, tmf_dpath.
//
//  channel  signals                              carries
//  cfg      cfg_valid / cfg_ready                cfg_window_count (N)
//  sample   smp_valid / smp_ready                smp_item (sample, channel)
//  result   res_valid / res_ready                res_item (average, result_channel)
//
// A sample inside a window is accumulated as it is taken; a pass-through
// sample loads the result register as it is taken. The sample that closes a
// window sends the controller to ST_TRIM to form the dividend, then to ST_DIV,
// where the radix-16 divider retires four quotient bits per cycle. Synchronous
// reset sets N to 8 and empties the window. A waiting result stalls only items
// that would make another result; cfg_ready is always high.
module trimmed_mean_sample_filter_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tmf_pkg::WC_W-1:0] cfg_window_count,
  input  logic                     smp_valid,
  output logic                     smp_ready,
  input  tmf_pkg::sample_item_t    smp_item,
  output logic                     res_valid,
  input  logic                     res_ready,
  output tmf_pkg::result_item_t    res_item
);

  tmf_pkg::tmf_cmd_t cmd;
  tmf_pkg::tmf_sts_t sts;

  assign cfg_ready = 1'b1;

  tmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmf_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_window_count (cfg_window_count),
    .smp_item         (smp_item),
    .cmd              (cmd),
    .sts              (sts),
    .res_item         (res_item)
  );

`ifndef NO_ASSERTIONS
  // A pass-through item shows its result on the next cycle
  a_pass_result: assert property (@(posedge clk) disable iff (rst)
    (smp_valid && smp_ready && sts.pass) |=> res_valid)
    else $error("pass-through item gave no result");

  // The item that closes a window blocks intake once taken, as the controller enters ST_TRIM
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (smp_valid && smp_ready && !sts.pass && sts.last) |=> !smp_ready)
    else $error("intake open after window close");

  // The result register is never loaded over an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_pass || (cmd.div_step && sts.div_end)) |-> !res_valid)
    else $error("result overwritten");
`endif

endmodule
